### design/resumable_window_download_receiver_unit_defines.svh
// assertion helpers used by the result queue
`ifndef RESUMABLE_WINDOW_DOWNLOAD_RECEIVER_UNIT_DEFINES_SVH
`define RESUMABLE_WINDOW_DOWNLOAD_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication under active-low reset
`define RWDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwdr check failed");

// next-cycle implication under active-low reset
`define RWDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwdr check failed");

`endif

### design/rwdr_pkg.sv
// ----------------------------------------------------------------------------
// rwdr_pkg
// Types and codes of the windowed download receiver.
// ----------------------------------------------------------------------------
package rwdr_pkg;

    localparam int unsigned WSIZE_W = 21;
    localparam int unsigned LIMIT_W = 8;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 21'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd40;

    // input function codes
    localparam logic [1:0] FUNC_START    = 2'd0;
    localparam logic [1:0] FUNC_RESPONSE = 2'd1;
    localparam logic [1:0] FUNC_FAILURE  = 2'd2;

    // payload kinds
    localparam logic [1:0] PAY_DATA  = 2'd0;
    localparam logic [1:0] PAY_ERROR = 2'd1;
    localparam logic [1:0] PAY_OTHER = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_WRITE      = 3'd0;
    localparam logic [2:0] KIND_READ       = 3'd1;
    localparam logic [2:0] KIND_DONE       = 3'd2;
    localparam logic [2:0] KIND_FAIL_ERR   = 3'd3;
    localparam logic [2:0] KIND_FAIL_STALL = 3'd4;

    // config register indexes
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_STALL_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_WAIT = 2'd1
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] resp_id;
        logic [1:0]  payload_kind;
        logic [31:0] chunk_offset;
        logic [15:0] chunk_size;
        logic        chunk_last;
        logic        more_follows;
    } beat_t;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic [31:0]        request_id;
        logic [31:0]        offset_value;
        logic [WSIZE_W-1:0] length_value;
        logic               drain_before;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [WSIZE_W-1:0] window_size;
        logic [LIMIT_W-1:0] stall_limit;
    } cfg_t;

endpackage

### design/rwdr_core.sv
// ----------------------------------------------------------------------------
// rwdr_core
// Download state and the per-beat decision logic; up to two results per beat.
// ----------------------------------------------------------------------------
module rwdr_core (
    input  logic              clk,
    input  logic              rst_n,
    input  rwdr_pkg::cfg_t    cfg,
    input  logic              in_fire,
    input  rwdr_pkg::beat_t   beat,
    output rwdr_pkg::result_t res0,
    output rwdr_pkg::result_t res1,
    output logic [1:0]        res_cnt
);
    import rwdr_pkg::*;

    logic [31:0]        rb_reg, rb_next;
    logic [31:0]        ws_reg, ws_next;
    logic [LIMIT_W-1:0] sc_reg, sc_next;
    logic [31:0]        cr_reg, cr_next;
    phase_t             phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_reg    <= '0;
            ws_reg    <= '0;
            sc_reg    <= '0;
            cr_reg    <= '0;
            phase_reg <= PHASE_IDLE;
        end
        else if (in_fire)
        begin
            rb_reg    <= rb_next;
            ws_reg    <= ws_next;
            sc_reg    <= sc_next;
            cr_reg    <= cr_next;
            phase_reg <= phase_next;
        end
    end

    logic        ew;
    logic        ew_last;
    logic [31:0] rb_eff;
    logic [32:0] end_sum;
    logic [31:0] end_clip;
    logic [31:0] delivered;
    logic [31:0] cr_inc;
    logic        do_finish;
    logic [2:0]  fin_kind;
    logic        do_issue;
    logic        issue_drain;
    result_t     r_ew;
    result_t     r_first;
    logic        have_write;

    assign cr_inc   = cr_reg + 32'd1;
    assign end_sum  = {1'b0, beat.chunk_offset} + {17'd0, beat.chunk_size};
    assign end_clip = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];

    always_comb
    begin
        rb_next     = rb_reg;
        ws_next     = ws_reg;
        sc_next     = sc_reg;
        cr_next     = cr_reg;
        phase_next  = phase_reg;
        ew          = 1'b0;
        ew_last     = 1'b0;
        rb_eff      = rb_reg;
        have_write  = 1'b0;
        do_finish   = 1'b0;
        fin_kind    = KIND_DONE;
        do_issue    = 1'b0;
        issue_drain = 1'b0;
        r_first     = '0;

        if (beat.func == FUNC_START)
        begin
            rb_next  = '0;
            rb_eff   = '0;
            sc_next  = '0;
            do_issue = 1'b1;
        end
        else if (phase_reg == PHASE_WAIT)
        begin
            if (beat.func == FUNC_FAILURE)
            begin
                ew = 1'b1;
            end
            else if (beat.func == FUNC_RESPONSE && beat.resp_id == cr_reg)
            begin
                if (beat.payload_kind == PAY_ERROR)
                begin
                    do_finish = 1'b1;
                    fin_kind  = (rb_reg != '0) ? KIND_DONE : KIND_FAIL_ERR;
                end
                else if (beat.payload_kind == PAY_DATA)
                begin
                    if (beat.chunk_offset > rb_reg)
                    begin
                        ew = 1'b1;
                    end
                    else
                    begin
                        if (end_clip > rb_reg)
                        begin
                            have_write           = 1'b1;
                            r_first.result_kind  = KIND_WRITE;
                            r_first.request_id   = cr_reg;
                            r_first.offset_value = rb_reg - beat.chunk_offset;
                            // at most one chunk size, so it fits the length field
                            r_first.length_value = WSIZE_W'(end_clip - rb_reg);
                            rb_eff               = end_clip;
                            rb_next              = end_clip;
                        end
                        if (beat.chunk_last)
                        begin
                            ew      = 1'b1;
                            ew_last = 1'b1;
                        end
                        else if (!beat.more_follows)
                        begin
                            ew = 1'b1;
                        end
                    end
                end
                else if (beat.payload_kind == PAY_OTHER && !beat.more_follows)
                begin
                    ew = 1'b1;
                end
            end
        end

        delivered = rb_eff - ws_reg;

        // end of window decision
        if (ew)
        begin
            if (ew_last && delivered < {11'd0, cfg.window_size})
            begin
                do_finish = 1'b1;
                fin_kind  = KIND_DONE;
            end
            else if (ew_last)
            begin
                sc_next  = '0;
                do_issue = 1'b1;
            end
            else if (delivered != '0)
            begin
                sc_next     = '0;
                do_issue    = 1'b1;
                issue_drain = 1'b1;
            end
            else if (sc_reg >= cfg.stall_limit)
            begin
                do_finish = 1'b1;
                fin_kind  = KIND_FAIL_STALL;
            end
            else
            begin
                sc_next     = sc_reg + 8'd1;
                do_issue    = 1'b1;
                issue_drain = 1'b1;
            end
        end

        r_ew = '0;
        if (do_issue)
        begin
            cr_next           = cr_inc;
            ws_next           = rb_eff;
            phase_next        = PHASE_WAIT;
            r_ew.result_kind  = KIND_READ;
            r_ew.request_id   = cr_inc;
            r_ew.offset_value = rb_eff;
            r_ew.length_value = cfg.window_size;
            r_ew.drain_before = issue_drain;
        end
        else if (do_finish)
        begin
            phase_next        = PHASE_IDLE;
            r_ew.result_kind  = fin_kind;
            r_ew.request_id   = cr_reg;
            r_ew.offset_value = rb_eff;
        end
        r_ew.last_of_run = 1'b1;

        if (have_write)
        begin
            res0 = r_first;
            res1 = r_ew;
            if (do_issue || do_finish)
            begin
                res_cnt = 2'd2;
            end
            else
            begin
                res0.last_of_run = 1'b1;
                res_cnt          = 2'd1;
            end
        end
        else
        begin
            res0    = r_ew;
            res1    = r_ew;
            res_cnt = (do_issue || do_finish) ? 2'd1 : 2'd0;
        end
    end

endmodule

### design/rwdr_result_queue.sv
// ----------------------------------------------------------------------------
// rwdr_result_queue
// Small result queue: takes up to two results a cycle while two slots are free, hands out one a beat.
// ----------------------------------------------------------------------------
`include "resumable_window_download_receiver_unit_defines.svh"

module rwdr_result_queue #(
    parameter int unsigned ADDR_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  rwdr_pkg::result_t push0,
    input  rwdr_pkg::result_t push1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output rwdr_pkg::result_t out_data
);
    import rwdr_pkg::*;

    localparam int unsigned DEPTH = 1 << ADDR_W;

    result_t           mem_reg [DEPTH];
    logic [ADDR_W-1:0] wptr_reg, wptr_next;
    logic [ADDR_W-1:0] rptr_reg, rptr_next;
    logic [ADDR_W:0]   count_reg, count_next;
    logic              pop;
    logic [ADDR_W-1:0] wptr_plus;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    // two free slots needed, since one beat may leave two results
    assign room      = (count_reg <= (ADDR_W+1)'(DEPTH - 2));
    assign wptr_plus = wptr_reg + ADDR_W'(1);

    always_comb
    begin
        wptr_next  = wptr_reg + ADDR_W'(push_cnt);
        rptr_next  = pop ? (rptr_reg + ADDR_W'(1)) : rptr_reg;
        count_next = count_reg + (ADDR_W+1)'(push_cnt) - (ADDR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wptr_plus] <= push1;
        end
    end

    `RWDR_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= (ADDR_W+1)'(DEPTH))
    `RWDR_ASSERT_IMPLY(a_push_room, clk, rst_n, push_cnt != 2'd0,
                       count_reg <= (ADDR_W+1)'(DEPTH - 2))
    `RWDR_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && push_cnt == 2'd0,
                      count_reg == $past(count_reg) - (ADDR_W+1)'(1))

endmodule

### design/resumable_window_download_receiver_unit.sv
// ----------------------------------------------------------------------------
// resumable_window_download_receiver_unit
// Receiver side of a windowed, resumable download: requests and write ranges.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries request beats: start, response descriptors and receive
//   failures. m_* carries results: write ranges, read requests and the final
//   finished or failed status; m_tlast marks the last result of one input beat.
//   window_size and stall_limit are written over the APB port; the user must
//   do so only while idle, unchecked by the block. Results queue in order.
// Throughput: one input beat per cycle while s_tready is high; a beat that
//   causes a write range and a request needs two output beats, so the m_* side
//   then sets the pace. The figure comes from the result queue, which holds
//   2^QUEUE_AW results and admits a beat only while two slots are free.
// Reset: download state clears to idle, registers go to window 4096 and stall
//   limit 40, the result queue empties.
// Stall: when m_tready stays low the queue fills and s_tready drops; nothing
//   is lost and the state only advances on accepted beats.
// ----------------------------------------------------------------------------
module resumable_window_download_receiver_unit #(
    parameter int unsigned QUEUE_AW = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // resp_id[31:0], chunk_offset[63:32], chunk_size[79:64], more_follows[80]
    input  logic [87:0] s_tdata,
    // func[1:0], payload_kind[3:2]
    input  logic [3:0]  s_tuser,
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // request_id[31:0], offset_value[63:32], length_value[84:64], drain_before[85]
    output logic [87:0] m_tdata,
    // result_kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import rwdr_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       cfg_wr;
    logic       in_fire;
    beat_t      beat;
    result_t    res0, res1, qout;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    logic       room;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW_SIZE: cfg_next.window_size = pwdata[WSIZE_W-1:0];
                REG_STALL_LIMIT: cfg_next.stall_limit = pwdata[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size <= WSIZE_RESET;
            cfg_reg.stall_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_SIZE: prdata = {11'd0, cfg_reg.window_size};
            REG_STALL_LIMIT: prdata = {24'd0, cfg_reg.stall_limit};
            default:         prdata = '0;
        endcase
    end

    assign beat.func         = s_tuser[1:0];
    assign beat.payload_kind = s_tuser[3:2];
    assign beat.resp_id      = s_tdata[31:0];
    assign beat.chunk_offset = s_tdata[63:32];
    assign beat.chunk_size   = s_tdata[79:64];
    assign beat.more_follows = s_tdata[80];
    assign beat.chunk_last   = s_tlast;

    assign s_tready = room;
    assign in_fire  = s_tvalid && s_tready;
    assign push_cnt = in_fire ? res_cnt : 2'd0;

    rwdr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .beat    (beat),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    rwdr_result_queue #(
        .ADDR_W (QUEUE_AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (qout)
    );

    assign m_tdata = {2'b00, qout.drain_before, qout.length_value,
                      qout.offset_value, qout.request_id};
    assign m_tuser = qout.result_kind;
    assign m_tlast = qout.last_of_run;

endmodule
